>>> rtl/forth_stack_unit_defines.svh
// Assertion helpers for the stack unit
`ifndef FORTH_STACK_UNIT_DEFINES_SVH
`define FORTH_STACK_UNIT_DEFINES_SVH
// Implication checked on every edge outside reset
`define FSU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsu check failed");
// Next-cycle implication
`define FSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsu check failed");
`endif

>>> rtl/fsu_pkg.sv
`default_nettype none
package fsu_pkg;
  localparam int DataDepth   = 32;
  localparam int ReturnDepth = 32;
  localparam int CellBits    = 32;
  localparam int DPtrBits    = $clog2(DataDepth);
  localparam int RPtrBits    = $clog2(ReturnDepth);
  localparam int DCntBits    = $clog2(DataDepth + 1);
  localparam int RCntBits    = $clog2(ReturnDepth + 1);

  typedef logic [CellBits-1:0] cell_t;

  typedef enum logic [4:0] {
    OP_LIT = 5'd0, OP_DUP = 5'd1, OP_2DUP = 5'd2, OP_QDUP = 5'd3, OP_DROP = 5'd4,
    OP_2DROP = 5'd5, OP_SWAP = 5'd6, OP_OVER = 5'd7, OP_ROT = 5'd8, OP_MROT = 5'd9,
    OP_ROLL = 5'd10, OP_MROLL = 5'd11, OP_PICK = 5'd12, OP_NIP = 5'd13,
    OP_TUCK = 5'd14, OP_DEPTH = 5'd15, OP_TOR = 5'd16, OP_RFROM = 5'd17,
    OP_RFETCH = 5'd18, OP_RPICK = 5'd19, OP_RDROP = 5'd20, OP_NOT = 5'd21
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_INDEX = 2'd3;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [31:0] literal;
  } in_word_t;

  typedef struct packed {
    logic [31:0] top_cell;
    logic [31:0] second_cell;
    logic [5:0]  data_depth;
    logic [5:0]  return_depth;
    logic [1:0]  status;
  } out_word_t;

  // Decoded command passed from front to back
  typedef struct packed {
    logic [4:0] cmd;
    cell_t      lit;
  } dec_t;
endpackage
`default_nettype wire

>>> rtl/fsu_front.sv
`default_nettype none
module fsu_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire fsu_pkg::in_word_t in_word,
  output logic                  q_valid,
  input  wire logic             q_take,
  output fsu_pkg::dec_t         q_word
);
  import fsu_pkg::*;

  // two-entry queue toward the back end
  dec_t       q_mem_r [2];
  dec_t       q_mem_nxt [2];
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       push, pop;
  dec_t       dec;

  // literal sign-extended/truncated to cell width
  always_comb begin
    dec.cmd = in_word.cmd;
    dec.lit = CellBits'($signed({{(CellBits > 32 ? CellBits - 32 : 1){in_word.literal[31]}},
                                 in_word.literal}));
  end

  assign in_stall = (q_cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_word   = q_mem_r[0];

  always_comb begin
    q_mem_nxt = q_mem_r;
    q_cnt_nxt = q_cnt_r;
    if (pop) begin
      q_mem_nxt[0] = q_mem_r[1];
      q_cnt_nxt    = q_cnt_nxt - 2'd1;
    end
    if (push) begin
      q_mem_nxt[q_cnt_nxt[0]] = dec;
      q_cnt_nxt               = q_cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
    q_mem_r <= q_mem_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/fsu_back.sv
`default_nettype none
module fsu_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_take,
  input  wire fsu_pkg::dec_t   q_word,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output fsu_pkg::out_word_t   out_word
);
  import fsu_pkg::*;

  // data stack as a row of cells, index 0 = top; return stack likewise
  cell_t                 d_r [DataDepth];
  cell_t                 d_nxt [DataDepth];
  cell_t                 rs_r [ReturnDepth];
  cell_t                 rs_nxt [ReturnDepth];
  logic [DCntBits-1:0]   n_r, n_nxt;
  logic [RCntBits-1:0]   r_r, r_nxt;
  logic                  ov_r;
  out_word_t             ow_r, ow_nxt;
  logic [1:0]            st;
  logic                  go;
  logic                  u_ok;
  logic [DPtrBits-1:0]   u_d;
  logic [RPtrBits-1:0]   u_r;
  cell_t                 top, sec;

  assign go     = q_valid && (!ov_r || !out_stall);
  assign q_take = go;
  assign top    = d_r[0];

  // index operand range check, sized against each stack
  always_comb begin
    u_ok = 1'b0;
    u_d  = top[DPtrBits-1:0];
    u_r  = top[RPtrBits-1:0];
    if (q_word.cmd == OP_RPICK) begin
      u_ok = !top[CellBits-1] && (top < CellBits'(r_r));
    end else begin
      u_ok = !top[CellBits-1] && (top < CellBits'(n_r - DCntBits'(1)));
    end
  end

  // execute one primitive
  always_comb begin
    d_nxt  = d_r;
    rs_nxt = rs_r;
    n_nxt  = n_r;
    r_nxt  = r_r;
    st     = ST_OK;
    case (q_word.cmd)
      OP_LIT, OP_DEPTH: begin
        if (n_r >= DCntBits'(DataDepth)) st = ST_OVER;
        else begin
          for (int i = 1; i < DataDepth; i++) d_nxt[i] = d_r[i-1];
          d_nxt[0] = (q_word.cmd == OP_LIT) ? q_word.lit : CellBits'(n_r);
          n_nxt = n_r + DCntBits'(1);
        end
      end
      OP_DUP, OP_OVER: begin
        if (n_r < DCntBits'(q_word.cmd == OP_DUP ? 1 : 2)) st = ST_UNDER;
        else if (n_r >= DCntBits'(DataDepth)) st = ST_OVER;
        else begin
          for (int i = 1; i < DataDepth; i++) d_nxt[i] = d_r[i-1];
          d_nxt[0] = (q_word.cmd == OP_DUP) ? d_r[0] : d_r[1];
          n_nxt = n_r + DCntBits'(1);
        end
      end
      OP_QDUP: begin
        if (n_r < DCntBits'(1)) st = ST_UNDER;
        else if (d_r[0] != '0) begin
          if (n_r >= DCntBits'(DataDepth)) st = ST_OVER;
          else begin
            for (int i = 1; i < DataDepth; i++) d_nxt[i] = d_r[i-1];
            n_nxt = n_r + DCntBits'(1);
          end
        end
      end
      OP_2DUP: begin
        if (n_r < DCntBits'(2)) st = ST_UNDER;
        else if (n_r + DCntBits'(2) > DCntBits'(DataDepth)) st = ST_OVER;
        else begin
          for (int i = 2; i < DataDepth; i++) d_nxt[i] = d_r[i-2];
          n_nxt = n_r + DCntBits'(2);
        end
      end
      OP_DROP, OP_2DROP, OP_NIP: begin
        if (n_r < DCntBits'(q_word.cmd == OP_DROP ? 1 : 2)) st = ST_UNDER;
        else if (q_word.cmd == OP_2DROP) begin
          for (int i = 0; i < DataDepth - 2; i++) d_nxt[i] = d_r[i+2];
          n_nxt = n_r - DCntBits'(2);
        end else begin
          for (int i = 1; i < DataDepth - 1; i++) d_nxt[i] = d_r[i+1];
          if (q_word.cmd == OP_DROP) d_nxt[0] = d_r[1];
          n_nxt = n_r - DCntBits'(1);
        end
      end
      OP_SWAP: begin
        if (n_r < DCntBits'(2)) st = ST_UNDER;
        else begin d_nxt[0] = d_r[1]; d_nxt[1] = d_r[0]; end
      end
      OP_ROT: begin
        if (n_r < DCntBits'(3)) st = ST_UNDER;
        else begin d_nxt[0] = d_r[2]; d_nxt[1] = d_r[0]; d_nxt[2] = d_r[1]; end
      end
      OP_MROT: begin
        if (n_r < DCntBits'(3)) st = ST_UNDER;
        else begin d_nxt[0] = d_r[1]; d_nxt[1] = d_r[2]; d_nxt[2] = d_r[0]; end
      end
      OP_ROLL, OP_MROLL: begin
        if (n_r < DCntBits'(1)) st = ST_UNDER;
        else if (!u_ok) st = ST_INDEX;
        else begin
          // cells 1..u+1 rotate; each cell picks locally
          for (int i = 0; i < DataDepth - 1; i++) d_nxt[i] = d_r[i+1];
          if (q_word.cmd == OP_ROLL) begin
            d_nxt[0] = d_r[u_d + DPtrBits'(1)];
            for (int i = 1; i < DataDepth - 1; i++)
              if (DPtrBits'(i) <= u_d) d_nxt[i] = d_r[i];
          end else begin
            for (int i = 0; i < DataDepth - 1; i++) begin
              if (DPtrBits'(i) < u_d) d_nxt[i] = d_r[i+2];
              else if (DPtrBits'(i) == u_d) d_nxt[i] = d_r[1];
            end
          end
          n_nxt = n_r - DCntBits'(1);
        end
      end
      OP_PICK: begin
        if (n_r < DCntBits'(1)) st = ST_UNDER;
        else if (!u_ok) st = ST_INDEX;
        else d_nxt[0] = d_r[u_d + DPtrBits'(1)];
      end
      OP_TUCK: begin
        if (n_r < DCntBits'(2)) st = ST_UNDER;
        else if (n_r >= DCntBits'(DataDepth)) st = ST_OVER;
        else begin
          for (int i = 3; i < DataDepth; i++) d_nxt[i] = d_r[i-1];
          d_nxt[2] = d_r[0];
          n_nxt = n_r + DCntBits'(1);
        end
      end
      OP_TOR: begin
        if (n_r < DCntBits'(1)) st = ST_UNDER;
        else if (r_r >= RCntBits'(ReturnDepth)) st = ST_OVER;
        else begin
          for (int i = 1; i < ReturnDepth; i++) rs_nxt[i] = rs_r[i-1];
          rs_nxt[0] = d_r[0];
          for (int i = 0; i < DataDepth - 1; i++) d_nxt[i] = d_r[i+1];
          n_nxt = n_r - DCntBits'(1);
          r_nxt = r_r + RCntBits'(1);
        end
      end
      OP_RFROM, OP_RFETCH: begin
        if (r_r < RCntBits'(1)) st = ST_UNDER;
        else if (n_r >= DCntBits'(DataDepth)) st = ST_OVER;
        else begin
          for (int i = 1; i < DataDepth; i++) d_nxt[i] = d_r[i-1];
          d_nxt[0] = rs_r[0];
          n_nxt = n_r + DCntBits'(1);
          if (q_word.cmd == OP_RFROM) begin
            for (int i = 0; i < ReturnDepth - 1; i++) rs_nxt[i] = rs_r[i+1];
            r_nxt = r_r - RCntBits'(1);
          end
        end
      end
      OP_RPICK: begin
        if (n_r < DCntBits'(1)) st = ST_UNDER;
        else if (!u_ok) st = ST_INDEX;
        else d_nxt[0] = rs_r[u_r];
      end
      OP_RDROP: begin
        if (r_r < RCntBits'(1)) st = ST_UNDER;
        else begin
          for (int i = 0; i < ReturnDepth - 1; i++) rs_nxt[i] = rs_r[i+1];
          r_nxt = r_r - RCntBits'(1);
        end
      end
      OP_NOT: begin
        if (n_r < DCntBits'(1)) st = ST_UNDER;
        else d_nxt[0] = (d_r[0] == '0) ? CellBits'(1) : '0;
      end
      default: st = ST_OK;
    endcase
  end

  // result word, cells sign-extended or cut to 32 bits
  always_comb begin
    sec = d_nxt[1];
    ow_nxt.top_cell     = (n_nxt >= DCntBits'(1)) ?
                          32'($signed(d_nxt[0])) : 32'd0;
    ow_nxt.second_cell  = (n_nxt >= DCntBits'(2)) ? 32'($signed(sec)) : 32'd0;
    ow_nxt.data_depth   = 6'(n_nxt);
    ow_nxt.return_depth = 6'(r_nxt);
    ow_nxt.status       = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r  <= '0;
      r_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      if (go) begin
        n_r <= n_nxt;
        r_r <= r_nxt;
      end
      if (go) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
    if (go) begin
      d_r  <= d_nxt;
      rs_r <= rs_nxt;
      ow_r <= ow_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;
endmodule
`default_nettype wire

>>> rtl/forth_stack_unit.sv
`default_nettype none
// Path: an accepted input word is written into the queue register, then the
// back end executes it into the result register; out_stall can hold a result
// in that register and so hold back later words.
// Throughput: one word per cycle while out_stall is low; every primitive,
// ROLL included, is combinational as each stack cell selects its next value.
// Reset (rst_n low, synchronous) empties the queue and both stacks and drops
// any pending result; cell contents are not cleared.
module forth_stack_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fsu_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fsu_pkg::out_word_t      out_word
);
  import fsu_pkg::*;
`include "forth_stack_unit_defines.svh"

  logic q_valid, q_take;
  dec_t q_word;

  // front: accept and queue
  fsu_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_word,
    .q_valid, .q_take, .q_word
  );

  // back: execute and hold result
  fsu_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_word,
    .out_valid, .out_stall, .out_word
  );

  `FSU_ASSERT_IMP(a_take_needs_valid, q_take, q_valid)
  `FSU_ASSERT_NEXT(a_take_gives_result, q_take, out_valid)
  `FSU_ASSERT_IMP(a_depth_bound, out_valid,
                  out_word.data_depth <= 6'd32 && out_word.return_depth <= 6'd32)
endmodule
`default_nettype wire
